@@ rtl/tdac_pkg.sv @@
`default_nettype none
package tdac_pkg;

  // time limits
  localparam int unsigned HOURS_PER_DAY   = 24;
  localparam int unsigned MINUTES_PER_HR  = 60;
  localparam int unsigned SECONDS_PER_MIN = 60;

  // shutoff used when the limit register holds zero
  localparam logic [15:0] DEFAULT_SHUTOFF = 16'd60;
  localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

  // configuration register map
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_ALARM_HOUR    = 2'd0,
    REG_ALARM_MINUTE  = 2'd1,
    REG_ALARM_ON      = 2'd2,
    REG_SHUTOFF_LIMIT = 2'd3
  } tdac_reg_t;

  // item modes
  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_SET_HMS    = 3'd1,
    MODE_SET_HM     = 3'd2,
    MODE_RING_START = 3'd3,
    MODE_RING_STOP  = 3'd4
  } tdac_mode_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] set_hour;
    logic [7:0] set_minute;
    logic [7:0] set_second;
  } tdac_in_t;

  typedef struct packed {
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic       alarm_match;
    logic       ringing;
  } tdac_out_t;

  typedef struct packed {
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic        alarm_on;
    logic [15:0] shutoff_limit;
  } tdac_cfg_t;

  // x mod 24 = 8 * ((x >> 3) mod 3) + x[2:0]
  function automatic logic [4:0] mod24_8(input logic [7:0] x);
    logic [4:0] y;
    logic [8:0] p;
    logic [3:0] q;
    logic [4:0] r;
    y = x[7:3];
    p = {4'd0, y} * 9'd11;
    q = p[8:5];
    r = y - ({1'b0, q} + {q, 1'b0});
    return {r[1:0], x[2:0]};
  endfunction

  // x mod 60 over an 8-bit value by compare and subtract
  function automatic logic [5:0] mod60_8(input logic [7:0] x);
    logic [7:0] d;
    if (x >= 8'd240)      d = x - 8'd240;
    else if (x >= 8'd180) d = x - 8'd180;
    else if (x >= 8'd120) d = x - 8'd120;
    else if (x >= 8'd60)  d = x - 8'd60;
    else                  d = x;
    return d[5:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/time_of_day_alarm_counter.sv @@
// an accepted input transaction is held in the input register, its result in the
// result register on out_data; throughput: one transaction per cycle unless out_stall
// backs up; time and ring state update in one tdac_core pass between both registers
// reset: rst_n is synchronous, active low; clears time, ring state and both
// pipeline valids; alarm registers go to 0 and shutoff_limit to 60
`default_nettype none
module time_of_day_alarm_counter #(
  parameter logic [15:0] DEFAULT_SHUTOFF = tdac_pkg::DEFAULT_SHUTOFF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire tdac_pkg::tdac_in_t               in_data,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tdac_pkg::tdac_out_t                   out_data,
  // apb-style configuration port
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [tdac_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [tdac_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [tdac_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                  cfg_pready
);

  tdac_pkg::tdac_cfg_t cfg;

  // input register stage
  logic               in_valid_r, in_valid_nxt;
  tdac_pkg::tdac_in_t in_data_r;

  // result register stage
  logic                out_valid_r, out_valid_nxt;
  tdac_pkg::tdac_out_t out_data_r;
  tdac_pkg::tdac_out_t res;

  logic in_take;
  logic advance;

  // the held item moves on whenever the result register is free or draining
  assign advance  = in_valid_r && !(out_valid_r && out_stall);
  // stall only while the input register is full and cannot move
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tdac_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // state update and result for the item in the input register
  tdac_core #(
    .DEFAULT_SHUTOFF (DEFAULT_SHUTOFF)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_data_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_comb begin
    if (in_take)      in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
    else              in_valid_nxt = in_valid_r;

    if (advance)         out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tdac_regs.sv @@
`default_nettype none
module tdac_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [tdac_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [tdac_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [tdac_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready,
  output tdac_pkg::tdac_cfg_t                      cfg
);

  tdac_pkg::tdac_cfg_t cfg_r;
  tdac_pkg::tdac_cfg_t cfg_nxt;
  tdac_pkg::tdac_reg_t reg_sel;
  logic                wr_en;

  assign reg_sel    = tdac_pkg::tdac_reg_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        tdac_pkg::REG_ALARM_HOUR:    cfg_nxt.alarm_hour    = cfg_pwdata[4:0];
        tdac_pkg::REG_ALARM_MINUTE:  cfg_nxt.alarm_minute  = cfg_pwdata[5:0];
        tdac_pkg::REG_ALARM_ON:      cfg_nxt.alarm_on      = cfg_pwdata[0];
        tdac_pkg::REG_SHUTOFF_LIMIT: cfg_nxt.shutoff_limit = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tdac_pkg::REG_ALARM_HOUR:    cfg_prdata = {27'd0, cfg_r.alarm_hour};
      tdac_pkg::REG_ALARM_MINUTE:  cfg_prdata = {26'd0, cfg_r.alarm_minute};
      tdac_pkg::REG_ALARM_ON:      cfg_prdata = {31'd0, cfg_r.alarm_on};
      tdac_pkg::REG_SHUTOFF_LIMIT: cfg_prdata = {16'd0, cfg_r.shutoff_limit};
      default:                     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_hour    <= '0;
      cfg_r.alarm_minute  <= '0;
      cfg_r.alarm_on      <= 1'b0;
      cfg_r.shutoff_limit <= 16'd60;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tdac_core.sv @@
`default_nettype none
module tdac_core #(
  parameter logic [15:0] DEFAULT_SHUTOFF = tdac_pkg::DEFAULT_SHUTOFF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire tdac_pkg::tdac_in_t  item,
  input  wire tdac_pkg::tdac_cfg_t cfg,
  output tdac_pkg::tdac_out_t      res
);

  logic [4:0]  hour_r,    hour_nxt;
  logic [5:0]  minute_r,  minute_nxt;
  logic [5:0]  second_r,  second_nxt;
  logic        ring_r,    ring_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;

  logic [15:0] elapsed_inc;
  logic [15:0] limit;

  assign limit       = (cfg.shutoff_limit == '0) ? DEFAULT_SHUTOFF
                                                  : cfg.shutoff_limit;
  assign elapsed_inc = (elapsed_r == tdac_pkg::ELAPSED_MAX) ? elapsed_r
                                                            : elapsed_r + 16'd1;

  always_comb begin
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    ring_nxt    = ring_r;
    elapsed_nxt = elapsed_r;
    unique case (tdac_pkg::tdac_mode_t'(item.mode))
      tdac_pkg::MODE_TICK: begin
        // cascaded seconds / minutes / hours rollover
        if (second_r == 6'(tdac_pkg::SECONDS_PER_MIN - 1)) begin
          second_nxt = '0;
          if (minute_r == 6'(tdac_pkg::MINUTES_PER_HR - 1)) begin
            minute_nxt = '0;
            hour_nxt   = (hour_r == 5'(tdac_pkg::HOURS_PER_DAY - 1)) ? '0
                                                                     : hour_r + 5'd1;
          end else begin
            minute_nxt = minute_r + 6'd1;
          end
        end else begin
          second_nxt = second_r + 6'd1;
        end
        // ring timer, saturating, auto stop at limit
        if (ring_r) begin
          if (elapsed_inc >= limit) begin
            ring_nxt    = 1'b0;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
      end
      tdac_pkg::MODE_SET_HMS: begin
        hour_nxt   = tdac_pkg::mod24_8(item.set_hour);
        minute_nxt = tdac_pkg::mod60_8(item.set_minute);
        second_nxt = tdac_pkg::mod60_8(item.set_second);
      end
      tdac_pkg::MODE_SET_HM: begin
        hour_nxt   = tdac_pkg::mod24_8(item.set_hour);
        minute_nxt = tdac_pkg::mod60_8(item.set_minute);
        second_nxt = '0;
      end
      tdac_pkg::MODE_RING_START: begin
        ring_nxt    = 1'b1;
        elapsed_nxt = '0;
      end
      tdac_pkg::MODE_RING_STOP: begin
        ring_nxt    = 1'b0;
        elapsed_nxt = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.hour_now    = hour_nxt;
    res.minute_now  = minute_nxt;
    res.second_now  = second_nxt;
    res.alarm_match = cfg.alarm_on && (hour_nxt == cfg.alarm_hour) &&
                      (minute_nxt == cfg.alarm_minute) && (second_nxt == '0);
    res.ringing     = ring_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r    <= '0;
      minute_r  <= '0;
      second_r  <= '0;
      ring_r    <= 1'b0;
      elapsed_r <= '0;
    end else if (advance) begin
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      second_r  <= second_nxt;
      ring_r    <= ring_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule
`default_nettype wire
